[src/pcmp_pkg.sv]
package pcmp_pkg;

	// Operation codes of an input word
	localparam logic [1:0] OpWrite  = 2'd0;
	localparam logic [1:0] OpRead   = 2'd1;
	localparam logic [1:0] OpRender = 2'd2;
	localparam logic [1:0] OpLoad   = 2'd3;

	// Channel register indexes
	localparam logic [2:0] RegStartLo = 3'd0;
	localparam logic [2:0] RegStartHi = 3'd1;
	localparam logic [2:0] RegLength  = 3'd2;
	localparam logic [2:0] RegVolume  = 3'd3;
	localparam logic [2:0] RegControl = 3'd4;

	localparam logic [7:0] ReadBad      = 8'hFF;
	localparam logic [8:0] RunFull      = 9'd256;
	localparam int         QueueDepth   = 4;
	localparam int         QueuePtrW    = 2;
	localparam int         QueueCountW  = 3;

	// Command handed from the front to the back
	typedef struct packed {
		logic [7:0]       read_data;
		logic [1:0]       busy_mask;
		logic [1:0]       fetch_en;
		logic [1:0][15:0] addr;
		logic [1:0][7:0]  vol;
		logic             mem_we;
		logic [7:0]       mem_byte;
	} cmd_t;

	// Head of the queue as seen by the back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

[src/pcmp_front.sv]
module pcmp_front #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [16:0]         cfg_wr_data,
	input  logic                push,
	input  logic [1:0]          op,
	input  logic [1:0]          channel,
	input  logic [2:0]          reg_index,
	input  logic [7:0]          write_data,
	input  logic [15:0]         mem_address,
	input  logic [7:0]          mem_byte,
	output pcmp_pkg::cmd_t      cmd
);

	localparam logic [16:0] MemDepthW = 17'(MEM_DEPTH);

	logic [16:0]      rom_bytes_q;
	logic [1:0][7:0]  base_lo_q, base_hi_q, len_q, vol_q;
	logic [1:0][1:0]  ctrl_q;
	logic [1:0]       last_trig_q, playing_q;
	logic [1:0][15:0] play_addr_q;
	logic [1:0][8:0]  left_q;

	logic [1:0][7:0]  base_lo_d, base_hi_d, len_d, vol_d;
	logic [1:0][1:0]  ctrl_d;
	logic [1:0]       last_trig_d, playing_d;
	logic [1:0][15:0] play_addr_d;
	logic [1:0][8:0]  left_d;

	logic [1:0][15:0] start_w;
	logic [1:0][8:0]  run_w;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			start_w[c] = {base_hi_q[c], base_lo_q[c]};
			run_w[c]   = (len_q[c] == 8'd0) ? pcmp_pkg::RunFull : {1'b0, len_q[c]};
		end
	end

	always_comb begin
		logic [8:0] left_m1;
		logic       sel;
		base_lo_d   = base_lo_q;
		base_hi_d   = base_hi_q;
		len_d       = len_q;
		vol_d       = vol_q;
		ctrl_d      = ctrl_q;
		last_trig_d = last_trig_q;
		playing_d   = playing_q;
		play_addr_d = play_addr_q;
		left_d      = left_q;
		cmd         = '0;
		left_m1     = '0;
		sel         = channel[0];

		case (op)
			pcmp_pkg::OpWrite: begin
				for (int c = 0; c < 2; c++) begin
					if (push && !channel[1] && sel == 1'(c)) begin
						case (reg_index)
							pcmp_pkg::RegStartLo: base_lo_d[c] = write_data;
							pcmp_pkg::RegStartHi: base_hi_d[c] = write_data;
							pcmp_pkg::RegLength:  len_d[c] = write_data;
							pcmp_pkg::RegVolume:  vol_d[c] = write_data;
							pcmp_pkg::RegControl: begin
								ctrl_d[c]      = write_data[1:0];
								last_trig_d[c] = write_data[0];
								// restart on a rising trigger edge
								if (write_data[0] && !last_trig_q[c]) begin
									play_addr_d[c] = start_w[c];
									left_d[c]      = run_w[c];
									playing_d[c]   = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			pcmp_pkg::OpRead: begin
				if (channel[1]) begin
					cmd.read_data = pcmp_pkg::ReadBad;
				end else begin
					case (reg_index)
						pcmp_pkg::RegStartLo: cmd.read_data = base_lo_q[sel];
						pcmp_pkg::RegStartHi: cmd.read_data = base_hi_q[sel];
						pcmp_pkg::RegLength:  cmd.read_data = len_q[sel];
						pcmp_pkg::RegVolume:  cmd.read_data = vol_q[sel];
						pcmp_pkg::RegControl: cmd.read_data = {playing_q[sel], 5'd0, ctrl_q[sel]};
						default:              cmd.read_data = pcmp_pkg::ReadBad;
					endcase
				end
			end
			pcmp_pkg::OpRender: begin
				for (int c = 0; c < 2; c++) begin
					cmd.addr[c] = play_addr_q[c];
					cmd.vol[c]  = vol_q[c];
					if (playing_q[c]) begin
						cmd.fetch_en[c] = ({1'b0, play_addr_q[c]} < rom_bytes_q) &&
							({1'b0, play_addr_q[c]} < MemDepthW);
						if (push) begin
							left_m1 = left_q[c] - 9'd1;
							play_addr_d[c] = play_addr_q[c] + 16'd1;
							left_d[c]      = left_m1;
							if (left_m1 == 9'd0) begin
								if (ctrl_q[c][1]) begin
									play_addr_d[c] = start_w[c];
									left_d[c]      = run_w[c];
								end else begin
									playing_d[c] = 1'b0;
								end
							end
						end
					end
				end
			end
			default: begin
				// sample memory load
				cmd.mem_we   = {1'b0, mem_address} < MemDepthW;
				cmd.addr[0]  = mem_address;
				cmd.mem_byte = mem_byte;
			end
		endcase
		cmd.busy_mask = playing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bytes_q <= '0;
			base_lo_q   <= '0;
			base_hi_q   <= '0;
			len_q       <= '0;
			vol_q       <= '0;
			ctrl_q      <= '0;
			last_trig_q <= '0;
			playing_q   <= '0;
			play_addr_q <= '0;
			left_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				rom_bytes_q <= cfg_wr_data;
			end
			base_lo_q   <= base_lo_d;
			base_hi_q   <= base_hi_d;
			len_q       <= len_d;
			vol_q       <= vol_d;
			ctrl_q      <= ctrl_d;
			last_trig_q <= last_trig_d;
			playing_q   <= playing_d;
			play_addr_q <= play_addr_d;
			left_q      <= left_d;
		end
	end

endmodule

[src/pcmp_queue.sv]
module pcmp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcmp_pkg::cmd_t      push_cmd,
	output logic                full,
	input  logic                pop,
	output pcmp_pkg::q_head_t   head
);

	pcmp_pkg::cmd_t                      entries_q [pcmp_pkg::QueueDepth];
	logic [pcmp_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [pcmp_pkg::QueueCountW-1:0]    count_q;

	assign full       = count_q == pcmp_pkg::QueueCountW'(pcmp_pkg::QueueDepth);
	assign head.valid = count_q != '0;
	assign head.cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/pcmp_back.sv]
module pcmp_back #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pcmp_pkg::q_head_t         head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                read_data,
	output logic signed [16:0]        mixed_sample,
	output logic [1:0]                busy_mask
);

	localparam int AddrW = $clog2(MEM_DEPTH);

	logic [7:0] mem_q [MEM_DEPTH];

	logic                    en;
	logic                    valid_s1, valid_s2, out_valid_q;
	pcmp_pkg::cmd_t          cmd_s1;
	logic [1:0][7:0]         byte_s1;
	logic [7:0]              rd_s2;
	logic [1:0]              busy_s2;
	logic signed [16:0]      prod0_s2, prod1_s2;
	logic signed [16:0]      smp0, smp1, vol0, vol1;
	logic [7:0]              read_data_q;
	logic signed [16:0]      mixed_q;
	logic [1:0]              busy_q;

	// whole back end advances together unless the output word is held
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && head.valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.cmd.mem_we) begin
				mem_q[head.cmd.addr[0][AddrW-1:0]] <= head.cmd.mem_byte;
			end
			byte_s1[0] <= mem_q[head.cmd.addr[0][AddrW-1:0]];
			byte_s1[1] <= mem_q[head.cmd.addr[1][AddrW-1:0]];
		end
	end

	// byte - 128 is the byte with its top bit inverted, as a signed value
	assign smp0 = {{10{~byte_s1[0][7]}}, byte_s1[0][6:0]};
	assign smp1 = {{10{~byte_s1[1][7]}}, byte_s1[1][6:0]};
	assign vol0 = {9'd0, cmd_s1.vol[0]};
	assign vol1 = {9'd0, cmd_s1.vol[1]};

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1      <= head.cmd;
			rd_s2       <= cmd_s1.read_data;
			busy_s2     <= cmd_s1.busy_mask;
			prod0_s2    <= cmd_s1.fetch_en[0] ? smp0 * vol0 : '0;
			prod1_s2    <= cmd_s1.fetch_en[1] ? smp1 * vol1 : '0;
			read_data_q <= rd_s2;
			mixed_q     <= prod0_s2 + prod1_s2;
			busy_q      <= busy_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= head.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign mixed_sample = mixed_q;
	assign busy_mask    = busy_q;

endmodule

[src/two_channel_pcm_sample_player.sv]
// Channel   Handshake               Payload
// in        in_valid / in_stall     op, channel, reg_index, write_data, mem_address, mem_byte
// out       out_valid / out_stall   read_data, mixed_sample, busy_mask
// cfg       cfg_wr_en               cfg_wr_data (sample memory bytes present)
//
// One word per cycle sustained while the output is not stalled. A word accepted into the
// queue leaves it into the memory read register, then passes the multiply and sum
// registers before its result is valid.
// Reset clears all channel registers, playback state and the queue; memory keeps its contents.
// An output stall freezes the back end; the front keeps taking words until the
// four-entry queue fills, then raises in_stall.
module two_channel_pcm_sample_player #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [16:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [1:0]          channel,
	input  logic [2:0]          reg_index,
	input  logic [7:0]          write_data,
	input  logic [15:0]         mem_address,
	input  logic [7:0]          mem_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          read_data,
	output logic signed [16:0]  mixed_sample,
	output logic [1:0]          busy_mask
);

	logic                 push, full, pop;
	pcmp_pkg::cmd_t       cmd;
	pcmp_pkg::q_head_t    head;

	// accept a word whenever the queue has room
	assign in_stall = full;
	assign push     = in_valid && !full;

	// Front: register file, trigger handling and playback advance all happen
	// at acceptance, so busy_mask and the fetch addresses are known up front.
	pcmp_front #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.op          (op),
		.channel     (channel),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.mem_address (mem_address),
		.mem_byte    (mem_byte),
		.cmd         (cmd)
	);

	// Hold classified words between front and back
	pcmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	// Back: sample memory loads and reads in queue order, then scale and mix
	pcmp_back #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.mixed_sample (mixed_sample),
		.busy_mask    (busy_mask)
	);

endmodule

[bench/tb.sv]
module tb;

	localparam int          RunLimit   = 300000;
	localparam int          SettleWait = 10;
	localparam int          SampleMid  = 128;
	localparam int          CtrlTrig   = 0;
	localparam int          CtrlLoop   = 1;
	localparam int          BusyFlag   = 7;
	localparam logic [16:0] RomFull    = 17'd65536;
	localparam int unsigned PhaseWords = 230;

	// One input word as it crosses the in channel
	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  channel;
		logic [2:0]  reg_index;
		logic [7:0]  write_data;
		logic [15:0] mem_address;
		logic [7:0]  mem_byte;
	} word_t;

	// One output word as it crosses the out channel
	typedef struct packed {
		logic [7:0]         read_data;
		logic signed [16:0] sample;
		logic [1:0]         busy;
	} reply_t;

	// Mirror of the player state plus the queue of replies still owed by the block
	class player_scoreboard;
		logic [7:0]  base_lo [2];
		logic [7:0]  base_hi [2];
		logic [7:0]  len_b [2];
		logic [7:0]  vol_b [2];
		logic [1:0]  ctrl [2];
		logic        trig_prev [2];
		logic [15:0] play_addr [2];
		logic [8:0]  left [2];
		logic        playing [2];
		logic [7:0]  mem [65536];
		bit          loaded [65536];
		logic [16:0] rom_present;
		reply_t      due_replies [$];
		int unsigned mismatches;

		function new();
			for (int c = 0; c < 2; c++) begin
				base_lo[c]   = '0;
				base_hi[c]   = '0;
				len_b[c]     = '0;
				vol_b[c]     = '0;
				ctrl[c]      = '0;
				trig_prev[c] = 1'b0;
				play_addr[c] = '0;
				left[c]      = '0;
				playing[c]   = 1'b0;
			end
			rom_present = '0;
			mismatches  = 0;
		endfunction

		function logic [15:0] start_of(int c);
			return {base_hi[c], base_lo[c]};
		endfunction

		function logic [8:0] run_of(int c);
			return (len_b[c] == 8'd0) ? pcmp_pkg::RunFull : {1'b0, len_b[c]};
		endfunction

		function void store_reg(int c, logic [2:0] idx, logic [7:0] d);
			case (idx)
				pcmp_pkg::RegStartLo: base_lo[c] = d;
				pcmp_pkg::RegStartHi: base_hi[c] = d;
				pcmp_pkg::RegLength:  len_b[c] = d;
				pcmp_pkg::RegVolume:  vol_b[c] = d;
				pcmp_pkg::RegControl: begin
					ctrl[c] = d[1:0];
					// only a fresh trigger edge (re)starts playback
					if (d[CtrlTrig] && !trig_prev[c]) begin
						play_addr[c] = start_of(c);
						left[c]      = run_of(c);
						playing[c]   = 1'b1;
					end
					trig_prev[c] = d[CtrlTrig];
				end
				default: ;
			endcase
		endfunction

		function logic [7:0] fetch_reg(int c, logic [2:0] idx);
			logic [7:0] v;
			case (idx)
				pcmp_pkg::RegStartLo: v = base_lo[c];
				pcmp_pkg::RegStartHi: v = base_hi[c];
				pcmp_pkg::RegLength:  v = len_b[c];
				pcmp_pkg::RegVolume:  v = vol_b[c];
				pcmp_pkg::RegControl: begin
					v = {6'd0, ctrl[c]};
					v[BusyFlag] = playing[c];
				end
				default:    v = pcmp_pkg::ReadBad;
			endcase
			return v;
		endfunction

		function logic signed [16:0] mix_frame();
			int sum;
			sum = 0;
			for (int c = 0; c < 2; c++) begin
				if (playing[c]) begin
					// past the present memory the channel plays silence
					if ({1'b0, play_addr[c]} < rom_present)
						sum += (int'(mem[play_addr[c]]) - SampleMid) * int'(vol_b[c]);
					play_addr[c] = play_addr[c] + 16'd1;
					left[c]      = left[c] - 9'd1;
					if (left[c] == 9'd0) begin
						if (ctrl[c][CtrlLoop]) begin
							play_addr[c] = start_of(c);
							left[c]      = run_of(c);
						end else begin
							playing[c] = 1'b0;
						end
					end
				end
			end
			return sum[16:0];
		endfunction

		function void note_word(word_t w);
			reply_t r;
			r.read_data = 8'd0;
			r.sample    = '0;
			case (w.op)
				pcmp_pkg::OpWrite:
					if (w.channel < 2'd2)
						store_reg(int'(w.channel), w.reg_index, w.write_data);
				pcmp_pkg::OpRead:   r.read_data = (w.channel < 2'd2) ?
					fetch_reg(int'(w.channel), w.reg_index) : pcmp_pkg::ReadBad;
				pcmp_pkg::OpRender: r.sample = mix_frame();
				default: begin
					mem[w.mem_address]    = w.mem_byte;
					loaded[w.mem_address] = 1'b1;
				end
			endcase
			r.busy = {playing[1], playing[0]};
			due_replies.push_back(r);
		endfunction

		function void check_word(reply_t got);
			reply_t want;
			if (due_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected output word read_data=%h sample=%0d busy=%b",
						$time, got.read_data, got.sample, got.busy);
				return;
			end
			want = due_replies.pop_front();
			if (got.read_data !== want.read_data || got.sample !== want.sample ||
					got.busy !== want.busy) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: output mismatch, expected read_data=%h sample=%0d busy=%b, %s",
						$time, want.read_data, want.sample, want.busy,
						$sformatf("got read_data=%h sample=%0d busy=%b",
							got.read_data, got.sample, got.busy));
			end
		endfunction

		function int unsigned pending();
			return due_replies.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [16:0]        cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = '0;
	logic [1:0]         channel = '0;
	logic [2:0]         reg_index = '0;
	logic [7:0]         write_data = '0;
	logic [15:0]        mem_address = '0;
	logic [7:0]         mem_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         read_data;
	logic signed [16:0] mixed_sample;
	logic [1:0]         busy_mask;

	player_scoreboard sb;
	int unsigned      words_sent = 0;
	int unsigned      burst_left = 0;
	int unsigned      cycle_count = 0;
	int unsigned      stall_tick = 0;
	int unsigned      mode_left = 0;
	logic [1:0]       stall_mode = '0;

	two_channel_pcm_sample_player u_top (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_valid,
		.in_stall,
		.op,
		.channel,
		.reg_index,
		.write_data,
		.mem_address,
		.mem_byte,
		.out_valid,
		.out_stall,
		.read_data,
		.mixed_sample,
		.busy_mask
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs or drops words
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RunLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver back-pressure: switch between free flow, sparse random stalls,
	// a fixed periodic pattern and heavy random stalling.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (mode_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			mode_left  <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			2'd0:    out_stall <= 1'b0;
			2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
			2'd2:    out_stall <= ((stall_tick % 6) < 2);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// Sample the out channel on the falling edge ahead of the rising edge that takes the word,
	// so the check never races the block's own updates.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word('{read_data, mixed_sample, busy_mask});
	end

	// Present one word, hold it until taken, then log it with the predictor.
	// Open a new burst with a random gap when the current one runs out.
	task automatic send_word(input word_t w);
		logic took;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		op          <= w.op;
		channel     <= w.channel;
		reg_index   <= w.reg_index;
		write_data  <= w.write_data;
		mem_address <= w.mem_address;
		mem_byte    <= w.mem_byte;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end
		sb.note_word(w);
		words_sent++;
	endtask

	// Fill every field with junk; callers overwrite the ones that matter
	function automatic word_t noise_word();
		word_t w;
		w.op          = 2'($urandom_range(0, 3));
		w.channel     = 2'($urandom_range(0, 3));
		w.reg_index   = 3'($urandom_range(0, 7));
		w.write_data  = 8'($urandom_range(0, 255));
		w.mem_address = 16'($urandom_range(0, 65535));
		w.mem_byte    = 8'($urandom_range(0, 255));
		return w;
	endfunction

	task automatic reg_write(input logic [1:0] ch, input logic [2:0] idx, input logic [7:0] d);
		word_t w;
		w = noise_word();
		w.op         = pcmp_pkg::OpWrite;
		w.channel    = ch;
		w.reg_index  = idx;
		w.write_data = d;
		send_word(w);
	endtask

	task automatic reg_read(input logic [1:0] ch, input logic [2:0] idx);
		word_t w;
		w = noise_word();
		w.op        = pcmp_pkg::OpRead;
		w.channel   = ch;
		w.reg_index = idx;
		send_word(w);
	endtask

	task automatic load_byte(input logic [15:0] a, input logic [7:0] b);
		word_t w;
		w = noise_word();
		w.op          = pcmp_pkg::OpLoad;
		w.mem_address = a;
		w.mem_byte    = b;
		send_word(w);
	endtask

	// Before a frame, load any byte a playing channel is about to fetch from
	// the present memory that was never written.
	task automatic render();
		word_t w;
		for (int c = 0; c < 2; c++) begin
			if (sb.playing[c] && {1'b0, sb.play_addr[c]} < sb.rom_present &&
					!sb.loaded[sb.play_addr[c]])
				load_byte(sb.play_addr[c], 8'($urandom_range(0, 255)));
		end
		w = noise_word();
		w.op = pcmp_pkg::OpRender;
		send_word(w);
	endtask

	// Drop valid and wait until every owed reply has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleWait) @(posedge clk);
	endtask

	task automatic set_rom(input logic [16:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.rom_present = v;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic directed();
		// both channels start on the top address and wrap to 0
		load_byte(16'hFFFF, 8'h00);
		load_byte(16'h0000, 8'hFF);
		load_byte(16'h0001, 8'h80);
		reg_write(2'd0, pcmp_pkg::RegStartLo, 8'hFF);
		reg_write(2'd0, pcmp_pkg::RegStartHi, 8'hFF);
		reg_write(2'd0, pcmp_pkg::RegLength, 8'd3);
		reg_write(2'd0, pcmp_pkg::RegVolume, 8'hFF);
		reg_write(2'd0, pcmp_pkg::RegControl, 8'h03);
		reg_read(2'd0, pcmp_pkg::RegControl);
		reg_write(2'd1, pcmp_pkg::RegStartLo, 8'hFF);
		reg_write(2'd1, pcmp_pkg::RegStartHi, 8'hFF);
		reg_write(2'd1, pcmp_pkg::RegVolume, 8'hFF);
		// length left at zero: a full 256-byte run
		reg_write(2'd1, pcmp_pkg::RegControl, 8'h01);
		// most negative mix, then most positive, then the midpoint
		render();
		render();
		render();
		render();
		// trigger held high: stores the bits, no restart
		reg_write(2'd0, pcmp_pkg::RegControl, 8'h01);
		// drop and raise the trigger to restart a running channel
		reg_write(2'd1, pcmp_pkg::RegControl, 8'h00);
		reg_write(2'd1, pcmp_pkg::RegControl, 8'h01);
		reg_write(2'd2, pcmp_pkg::RegVolume, 8'h55);
		reg_read(2'd3, pcmp_pkg::RegLength);
		reg_write(2'd0, 3'd7, 8'hAA);
		reg_read(2'd1, 3'd5);
		render();
		reg_read(2'd1, pcmp_pkg::RegControl);
	endtask

	// Program one channel and play it for a while, with reads mixed in
	task automatic play_sequence();
		logic [1:0]  ch;
		logic [15:0] start;
		logic [7:0]  len;
		logic [7:0]  d;
		logic        loop_on;
		int unsigned frames;
		int unsigned pick;
		ch = 2'($urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: start = 16'($urandom_range(0, 65535));
			1: start = (sb.rom_present > 17'd4) ?
				16'(sb.rom_present - 17'($urandom_range(1, 4))) : 16'($urandom_range(0, 65535));
			default: start = 16'hFFFF - 16'($urandom_range(0, 3));
		endcase
		pick = $urandom_range(0, 9);
		if (pick < 7)
			len = 8'($urandom_range(1, 6));
		else if (pick == 7)
			len = 8'd0;
		else
			len = 8'($urandom_range(0, 255));
		loop_on = 1'($urandom_range(0, 1));
		reg_write(ch, pcmp_pkg::RegStartLo, start[7:0]);
		reg_write(ch, pcmp_pkg::RegStartHi, start[15:8]);
		reg_write(ch, pcmp_pkg::RegLength, len);
		if ($urandom_range(0, 3) != 0)
			reg_write(ch, pcmp_pkg::RegVolume, 8'($urandom_range(0, 255)));
		// usually clear the trigger first so the next write is an edge
		if ($urandom_range(0, 4) != 0) begin
			d = 8'($urandom_range(0, 255));
			d[CtrlTrig] = 1'b0;
			d[CtrlLoop] = loop_on;
			reg_write(ch, pcmp_pkg::RegControl, d);
		end
		d = 8'($urandom_range(0, 255));
		d[CtrlTrig] = 1'b1;
		d[CtrlLoop] = loop_on;
		reg_write(ch, pcmp_pkg::RegControl, d);
		frames = $urandom_range(1, 12);
		repeat (frames) begin
			if ($urandom_range(0, 5) == 0)
				reg_read(ch, 3'($urandom_range(0, 7)));
			render();
		end
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		word_t w;
		stop_at = words_sent + quota;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				play_sequence();
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 8)) render();
			end else if (pick < 90) begin
				reg_read(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
			end else if (pick < 95) begin
				w = noise_word();
				w.op = pcmp_pkg::OpWrite;
				send_word(w);
			end else begin
				load_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [16:0] rom_plan [6];
		sb = new();
		rom_plan[0] = 17'd0;
		rom_plan[1] = RomFull;
		rom_plan[2] = 17'($urandom_range(1, 65535));
		rom_plan[3] = 17'($urandom_range(1, 700));
		rom_plan[4] = 17'd65535;
		rom_plan[5] = RomFull;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_rom(RomFull);
		directed();
		for (int p = 0; p < 6; p++) begin
			set_rom(rom_plan[p]);
			random_phase(PhaseWords);
		end
		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
